### rtl/core/krt_pkg.sv
// Types and constants shared by the keyed record table files.
package krt_pkg;

  localparam int KRT_DEPTH = 64;
  localparam int KEY_W     = 32;
  localparam int MIN_W     = 10;
  localparam int SEC_W     = 6;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 3;
  localparam logic [SEC_W-1:0] SEC_MAX = SEC_W'(59);

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_LOOKUP = 3'd1,
    REQ_UPDATE = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_LIST   = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUP       = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_DUR   = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_KEPT      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LRD,
    S_LEMIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [MIN_W-1:0] mins;
    logic [SEC_W-1:0] secs;
  } entry_t;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [MIN_W-1:0] mins;
    logic [SEC_W-1:0] secs;
    logic             last;
  } rsp_t;

endpackage

### rtl/core/krt_req_if.sv
// Request channel of the keyed record table.
interface krt_req_if
  import krt_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [KEY_W-1:0]  record_key;
  logic [MIN_W-1:0]         dur_minutes;
  logic [SEC_W-1:0]         dur_seconds;

  modport source (output valid, req_type, record_key, dur_minutes, dur_seconds,
                  input ready);
  modport sink   (input valid, req_type, record_key, dur_minutes, dur_seconds,
                  output ready);
endinterface

### rtl/core/krt_rsp_if.sv
// Result channel of the keyed record table.
interface krt_rsp_if
  import krt_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [KEY_W-1:0]  entry_key;
  logic [MIN_W-1:0]         out_minutes;
  logic [SEC_W-1:0]         out_seconds;
  logic                     last;

  modport source (output valid, status, entry_key, out_minutes, out_seconds, last,
                  input ready);
  modport sink   (input valid, status, entry_key, out_minutes, out_seconds, last,
                  output ready);
endinterface

### rtl/core/keyed_record_table.sv
// Keyed record table: ordered records in one synchronous memory, scanned per request.
//
//   channel | dir | handshake   | words per request
//   --------+-----+-------------+-----------------------------------------
//   req     | in  | valid/ready | one
//   rsp     | out | valid/ready | one, or one per record for list
//
// One request at a time; req.ready is high in idle, also while a result waits.
// Key search reads one entry a cycle; a delete then shifts the tail down one
// slot, and S_RESP posts the result. List reads and emits each record in
// turn through the single read port. rst empties the table at once.
// A stalled rsp holds the output register and stops the sequencer at its
// next result word.
module keyed_record_table
  import krt_pkg::*;
#(
  parameter int DEPTH = KRT_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  krt_req_if.sink  req,
  krt_rsp_if.source rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t            mem [DEPTH];
  entry_t            rd_data;

  state_t            state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [CW-1:0]     ptr, ptr_next;
  logic [CW-1:0]     pend_idx, pend_idx_next;
  logic              pend, pend_next;
  req_kind_t         kind, kind_next;
  entry_t            arg, arg_next;
  rsp_t              res, res_next;
  rsp_t              out_q, out_next;
  logic              out_vld, out_vld_next;

  logic              we;
  logic [AW-1:0]     wa;
  entry_t            wd;

  logic              accept, can_load, more, hit, full, empty, arg_ok, list_last;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign can_load  = !out_vld || rsp.ready;
  assign more      = ptr < cnt;
  assign hit       = pend && (rd_data.key == arg.key);
  assign full      = cnt == CW'(DEPTH);
  assign empty     = cnt == '0;
  assign arg_ok    = arg.secs <= SEC_MAX;
  assign list_last = CW'(ptr + CW'(1)) == cnt;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ptr[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_kind_t'(req.req_type))
            REQ_INSERT: state_next = full ? S_RESP : S_SCAN;
            REQ_LOOKUP, REQ_UPDATE, REQ_DELETE: state_next = empty ? S_RESP : S_SCAN;
            REQ_LIST:   state_next = empty ? S_RESP : S_LRD;
            default:    state_next = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_next = (kind == REQ_DELETE) ? S_SHIFT : S_RESP;
        end else if (!pend && !more) begin
          state_next = S_RESP;
        end
      end
      S_SHIFT: begin
        if (!pend && !more) begin
          state_next = S_RESP;
        end
      end
      S_LRD: state_next = S_LEMIT;
      S_LEMIT: begin
        if (can_load) begin
          state_next = list_last ? S_IDLE : S_LRD;
        end
      end
      S_RESP: begin
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_next      = cnt;
    ptr_next      = ptr;
    pend_next     = pend;
    pend_idx_next = pend_idx;
    kind_next     = kind;
    arg_next      = arg;
    res_next      = res;
    out_next      = out_q;
    out_vld_next  = out_vld && !rsp.ready;
    we            = 1'b0;
    wa            = ptr[AW-1:0];
    wd            = arg;
    case (state)
      S_IDLE: begin
        if (accept) begin
          kind_next     = req_kind_t'(req.req_type);
          arg_next.key  = req.record_key;
          arg_next.mins = req.dur_minutes;
          arg_next.secs = req.dur_seconds;
          ptr_next      = '0;
          pend_next     = 1'b0;
          res_next      = '{status: ST_OK, key: '0, mins: '0, secs: '0, last: 1'b1};
          case (req_kind_t'(req.req_type))
            REQ_INSERT: begin
              if (full) begin
                res_next.status = ST_FULL;
              end
            end
            REQ_LOOKUP, REQ_UPDATE, REQ_DELETE, REQ_LIST: begin
              if (empty) begin
                res_next.status = ST_EMPTY;
              end
            end
            REQ_CLEAR: cnt_next = '0;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          pend_next = 1'b0;
          case (kind)
            REQ_INSERT: res_next.status = ST_DUP;
            REQ_LOOKUP: begin
              res_next.key  = rd_data.key;
              res_next.mins = rd_data.mins;
              res_next.secs = rd_data.secs;
            end
            REQ_UPDATE: begin
              res_next.key = rd_data.key;
              if (arg_ok) begin
                we            = 1'b1;
                wa            = pend_idx[AW-1:0];
                wd            = arg;
                res_next.mins = arg.mins;
                res_next.secs = arg.secs;
              end else begin
                res_next.status = ST_KEPT;
                res_next.mins   = rd_data.mins;
                res_next.secs   = rd_data.secs;
              end
            end
            default: ;
          endcase
        end else if (more) begin
          pend_next     = 1'b1;
          pend_idx_next = ptr;
          ptr_next      = CW'(ptr + CW'(1));
        end else if (pend) begin
          pend_next = 1'b0;
        end else if (kind == REQ_INSERT) begin
          if (arg_ok) begin
            we       = 1'b1;
            wa       = cnt[AW-1:0];
            wd       = arg;
            cnt_next = CW'(cnt + CW'(1));
          end else begin
            res_next.status = ST_BAD_DUR;
          end
        end else begin
          res_next.status = ST_NOT_FOUND;
        end
      end
      S_SHIFT: begin
        if (pend) begin
          we = 1'b1;
          wa = AW'(pend_idx - CW'(1));
          wd = rd_data;
        end
        if (more) begin
          pend_next     = 1'b1;
          pend_idx_next = ptr;
          ptr_next      = CW'(ptr + CW'(1));
        end else begin
          pend_next = 1'b0;
        end
        if (!pend && !more) begin
          cnt_next = CW'(cnt - CW'(1));
        end
      end
      S_LEMIT: begin
        if (can_load) begin
          out_vld_next = 1'b1;
          out_next     = '{status: ST_OK, key: rd_data.key, mins: rd_data.mins,
                           secs: rd_data.secs, last: list_last};
          ptr_next     = CW'(ptr + CW'(1));
        end
      end
      S_RESP: begin
        if (can_load) begin
          out_vld_next = 1'b1;
          out_next     = res;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      ptr     <= '0;
      pend    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      ptr     <= ptr_next;
      pend    <= pend_next;
      out_vld <= out_vld_next;
    end
    pend_idx <= pend_idx_next;
    kind     <= kind_next;
    arg      <= arg_next;
    res      <= res_next;
    out_q    <= out_next;
  end

  assign rsp.valid       = out_vld;
  assign rsp.status      = out_q.status;
  assign rsp.entry_key   = out_q.key;
  assign rsp.out_minutes = out_q.mins;
  assign rsp.out_seconds = out_q.secs;
  assign rsp.last        = out_q.last;

endmodule

### bench/tb_keyed_record_table.sv
// Self-checking testbench for keyed_record_table: queued requests, table predictor, word checks.
`timescale 1ns / 1ps

module tb_keyed_record_table
  import krt_pkg::*;
();

  localparam logic [REQ_W-1:0] REQ_SPARE_A = REQ_W'(6);
  localparam logic [REQ_W-1:0] REQ_SPARE_B = REQ_W'(7);
  localparam logic [KEY_W-1:0] KEY_MIN     = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX     = 32'h7FFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_NEG1    = 32'hFFFF_FFFF;
  localparam logic [MIN_W-1:0] MINS_TOP    = '1;
  localparam logic [SEC_W-1:0] SECS_TOP    = '1;
  localparam logic [SEC_W-1:0] SECS_BAD    = SEC_MAX + SEC_W'(1);
  localparam int               CALM_TAIL   = 60;
  localparam int               DRAIN_WAIT  = 300;

  typedef struct {
    logic [REQ_W-1:0] kind;
    logic [KEY_W-1:0] key;
    logic [MIN_W-1:0] mins;
    logic [SEC_W-1:0] secs;
    bit               hold;
  } table_req_t;

  logic clk;
  logic rst;

  krt_req_if req_if ();
  krt_rsp_if rsp_if ();

  keyed_record_table i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  table_req_t       pending_reqs[$];
  table_req_t       in_flight;
  rsp_t             expected_words[$];
  logic [KEY_W-1:0] key_pool[$];
  logic [KEY_W-1:0] fill_keys[$];

  logic [KEY_W-1:0] rec_keys[KRT_DEPTH];
  logic [15:0]      rec_durs[KRT_DEPTH];
  int               rec_count;

  int err_cnt;
  int sent_cnt;
  int words_checked;
  int peak_count;
  int full_rejects;
  int gap_left;
  int stall_left;
  bit calm;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  function automatic int locate_key(input logic [KEY_W-1:0] k);
    for (int i = 0; i < rec_count; i++) begin
      if (rec_keys[i] == k) return i;
    end
    return rec_count;
  endfunction

  task automatic expect_word(input status_t st, input logic [KEY_W-1:0] k,
                             input logic [15:0] d, input bit fin);
    rsp_t w;
    w.status = st;
    w.key    = k;
    w.mins   = MIN_W'(d / 16'd60);
    w.secs   = SEC_W'(d % 16'd60);
    w.last   = fin;
    expected_words.push_back(w);
  endtask

  task automatic predict_table(input table_req_t r);
    int          pos;
    bit          dur_ok;
    logic [15:0] dur;
    dur_ok = (r.secs <= SEC_MAX);
    dur    = r.mins * 16'd60 + r.secs;
    pos    = locate_key(r.key);
    case (r.kind)
      REQ_INSERT: begin
        if (rec_count >= KRT_DEPTH) begin
          full_rejects++;
          expect_word(ST_FULL, '0, '0, 1'b1);
        end else if (pos < rec_count) begin
          expect_word(ST_DUP, '0, '0, 1'b1);
        end else if (!dur_ok) begin
          expect_word(ST_BAD_DUR, '0, '0, 1'b1);
        end else begin
          rec_keys[rec_count] = r.key;
          rec_durs[rec_count] = dur;
          rec_count++;
          if (rec_count > peak_count) peak_count = rec_count;
          expect_word(ST_OK, '0, '0, 1'b1);
        end
      end
      REQ_LOOKUP, REQ_UPDATE, REQ_DELETE: begin
        if (rec_count == 0) begin
          expect_word(ST_EMPTY, '0, '0, 1'b1);
        end else if (pos >= rec_count) begin
          expect_word(ST_NOT_FOUND, '0, '0, 1'b1);
        end else if (r.kind == REQ_LOOKUP) begin
          expect_word(ST_OK, r.key, rec_durs[pos], 1'b1);
        end else if (r.kind == REQ_UPDATE) begin
          if (dur_ok) rec_durs[pos] = dur;
          expect_word(dur_ok ? ST_OK : ST_KEPT, r.key, rec_durs[pos], 1'b1);
        end else begin
          for (int i = pos; i + 1 < rec_count; i++) begin
            rec_keys[i] = rec_keys[i+1];
            rec_durs[i] = rec_durs[i+1];
          end
          rec_count--;
          expect_word(ST_OK, '0, '0, 1'b1);
        end
      end
      REQ_LIST: begin
        if (rec_count == 0) begin
          expect_word(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < rec_count; i++) begin
            expect_word(ST_OK, rec_keys[i], rec_durs[i], i + 1 == rec_count);
          end
        end
      end
      REQ_CLEAR: begin
        rec_count = 0;
        expect_word(ST_OK, '0, '0, 1'b1);
      end
      default: begin
        expect_word(ST_OK, '0, '0, 1'b1);
      end
    endcase
  endtask

  task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [MIN_W-1:0] mins, input logic [SEC_W-1:0] secs,
                           input bit hold = 1'b0);
    table_req_t r;
    r.kind = kind;
    r.key  = key;
    r.mins = mins;
    r.secs = secs;
    r.hold = hold;
    pending_reqs.push_back(r);
  endtask

  function automatic table_req_t rand_req();
    table_req_t r;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 34)      r.kind = REQ_INSERT;
    else if (pick < 50) r.kind = REQ_LOOKUP;
    else if (pick < 64) r.kind = REQ_UPDATE;
    else if (pick < 82) r.kind = REQ_DELETE;
    else if (pick < 92) r.kind = REQ_LIST;
    else if (pick < 96) r.kind = REQ_CLEAR;
    else if (pick < 98) r.kind = REQ_SPARE_A;
    else                r.kind = REQ_SPARE_B;
    if ($urandom_range(0, 4) == 0) r.key = $urandom;
    else r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    r.mins = MIN_W'($urandom_range(0, 1023));
    if ($urandom_range(0, 6) == 0) r.secs = SEC_W'($urandom_range(60, 63));
    else r.secs = SEC_W'($urandom_range(0, 59));
    r.hold = 1'b0;
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_table(in_flight);
        sent_cnt++;
        if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 19);
      end
      calm = (pending_reqs.size() < CALM_TAIL);
      if (req_if.valid && !req_if.ready) begin
        // hold the word until taken
      end else if (gap_left != 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].hold && expected_words.size() != 0)) begin
        in_flight = pending_reqs.pop_front();
        req_if.valid       <= 1'b1;
        req_if.req_type    <= in_flight.kind;
        req_if.record_key  <= in_flight.key;
        req_if.dur_minutes <= in_flight.mins;
        req_if.dur_seconds <= in_flight.secs;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word status=%0d key=%h",
                                    rsp_if.status, rsp_if.entry_key));
        end else begin
          rsp_t w;
          w = expected_words.pop_front();
          words_checked++;
          if (rsp_if.status !== w.status)
            report_mismatch($sformatf("word %0d status got %0d want %0d",
                                      words_checked, rsp_if.status, w.status));
          if (rsp_if.entry_key !== w.key)
            report_mismatch($sformatf("word %0d entry_key got %h want %h",
                                      words_checked, rsp_if.entry_key, w.key));
          if (rsp_if.out_minutes !== w.mins)
            report_mismatch($sformatf("word %0d out_minutes got %0d want %0d",
                                      words_checked, rsp_if.out_minutes, w.mins));
          if (rsp_if.out_seconds !== w.secs)
            report_mismatch($sformatf("word %0d out_seconds got %0d want %0d",
                                      words_checked, rsp_if.out_seconds, w.secs));
          if (rsp_if.last !== w.last)
            report_mismatch($sformatf("word %0d last got %b want %b",
                                      words_checked, rsp_if.last, w.last));
        end
      end
      if (stall_left != 0) stall_left--;
      else if (!calm && $urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 19);
      rsp_if.ready <= (stall_left == 0);
    end
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    table_req_t r;
    rst                = 1'b1;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_INSERT;
    req_if.record_key  = '0;
    req_if.dur_minutes = '0;
    req_if.dur_seconds = '0;
    rsp_if.ready       = 1'b0;
    rec_count          = 0;
    err_cnt            = 0;
    sent_cnt           = 0;
    words_checked      = 0;
    peak_count         = 0;
    full_rejects       = 0;
    gap_left           = 0;
    stall_left         = 0;
    calm               = 1'b0;

    queue_req(REQ_LIST,    '0,       '0,       '0);
    queue_req(REQ_LOOKUP,  KEY_MIN,  '0,       '0);
    queue_req(REQ_UPDATE,  KEY_MAX,  10'd3,    6'd4);
    queue_req(REQ_DELETE,  '0,       '0,       '0);
    queue_req(REQ_INSERT,  KEY_MIN,  '0,       '0);
    queue_req(REQ_INSERT,  KEY_MAX,  MINS_TOP, SEC_MAX);
    queue_req(REQ_INSERT,  KEY_MIN,  10'd5,    6'd5);
    queue_req(REQ_INSERT,  '0,       10'd1,    SECS_BAD);
    queue_req(REQ_INSERT,  '0,       10'd1,    SECS_TOP);
    queue_req(REQ_INSERT,  KEY_NEG1, 10'd999,  SEC_MAX);
    queue_req(REQ_LOOKUP,  KEY_MAX,  '0,       '0);
    queue_req(REQ_LOOKUP,  '0,       '0,       '0);
    queue_req(REQ_UPDATE,  KEY_MAX,  10'd7,    SECS_TOP);
    queue_req(REQ_UPDATE,  KEY_MAX,  10'd1,    6'd1);
    queue_req(REQ_UPDATE,  '0,       10'd1,    6'd1);
    queue_req(REQ_LIST,    '0,       '0,       '0);
    queue_req(REQ_DELETE,  KEY_MIN,  '0,       '0);
    queue_req(REQ_DELETE,  32'h1234, '0,       '0);
    queue_req(REQ_LIST,    '0,       '0,       '0);
    queue_req(REQ_SPARE_A, KEY_NEG1, MINS_TOP, SECS_TOP);
    queue_req(REQ_SPARE_B, KEY_MAX,  10'd2,    6'd2);
    queue_req(REQ_LOOKUP,  KEY_NEG1, '0,       '0);
    queue_req(REQ_CLEAR,   '0,       '0,       '0);
    queue_req(REQ_LIST,    '0,       '0,       '0);
    queue_req(REQ_LOOKUP,  KEY_NEG1, '0,       '0);

    key_pool = '{KEY_MIN, KEY_MAX, '0, KEY_NEG1};
    repeat (8) key_pool.push_back($urandom);
    for (int i = 0; i < 180; i++) begin
      r = rand_req();
      if (i == 0) r.hold = 1'b1;
      pending_reqs.push_back(r);
    end

    queue_req(REQ_CLEAR, '0, '0, '0, 1'b1);
    for (int i = 0; i < KRT_DEPTH; i++) begin
      fill_keys.push_back(($urandom & ~32'hFF) | i);
      queue_req(REQ_INSERT, fill_keys[i], MIN_W'($urandom_range(0, 1023)),
                SEC_W'($urandom_range(0, 59)));
    end
    queue_req(REQ_INSERT, 32'h5A5A_5AFF, 10'd1, 6'd1);
    queue_req(REQ_INSERT, fill_keys[3], 10'd1, SECS_BAD);
    queue_req(REQ_LIST,   '0, '0, '0);
    queue_req(REQ_LOOKUP, fill_keys[KRT_DEPTH-1], '0, '0);
    queue_req(REQ_UPDATE, fill_keys[KRT_DEPTH-1], MINS_TOP, SEC_MAX);
    queue_req(REQ_UPDATE, fill_keys[0], 10'd9, SECS_BAD);
    queue_req(REQ_DELETE, fill_keys[0], '0, '0);
    queue_req(REQ_DELETE, fill_keys[KRT_DEPTH-1], '0, '0);
    queue_req(REQ_DELETE, fill_keys[KRT_DEPTH/2], '0, '0);
    queue_req(REQ_LOOKUP, fill_keys[KRT_DEPTH/2], '0, '0);
    queue_req(REQ_LIST,   '0, '0, '0);

    key_pool = fill_keys;
    key_pool.push_back(KEY_MIN);
    key_pool.push_back(KEY_MAX);
    for (int i = 0; i < 190; i++) begin
      r = rand_req();
      if (i == 0) r.hold = 1'b1;
      if (r.kind == REQ_CLEAR && i < 100) r.kind = REQ_INSERT;
      pending_reqs.push_back(r);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || expected_words.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d requests and %0d result words; table peaked at %0d of %0d records.",
             sent_cnt, words_checked, peak_count, KRT_DEPTH);
    $display("Full-table rejections seen: %0d; words still awaited: %0d.",
             full_rejects, expected_words.size());
    if (err_cnt == 0 && expected_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### keyed_record_table.f
rtl/core/krt_pkg.sv
rtl/core/krt_req_if.sv
rtl/core/krt_rsp_if.sv
rtl/core/keyed_record_table.sv
bench/tb_keyed_record_table.sv
